// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the silence detector rtl
// expects clk, and rst for ASD_ASSERT, in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/asd_pkg.sv -----
// types and constants of the audio silence timeout detector
// no dependencies; used by every rtl module of the block
package asd_pkg;

  // field and register widths
  localparam int SMP_W  = 16;
  localparam int TMO_W  = 13;
  localparam int BPS_W  = 21;
  localparam int THR_W  = 15;
  localparam int SB_W   = 32;
  localparam int TGT_W  = 33;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  // a block is loud when loud_count is nonzero and loud_count >= floor(4n/100) = floor(n/25)
  localparam int LOUD_DIV = 100 / 4;

  // register reset values; threshold is 1% of full scale
  localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(20);
  localparam logic [BPS_W-1:0] BPS_RST = BPS_W'(176400);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(32767 * 1 / 100);

  // register map, one 32-bit word per register
  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_BPS       = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    block_end;
  } sample_word_t;

  typedef struct packed {
    logic silence_reached;
    logic block_loud;
  } result_word_t;

  // settings seen by the datapath
  typedef struct packed {
    logic             tmo_neg;
    logic [THR_W-1:0] threshold;
    logic [TGT_W-1:0] target;
  } cfg_t;

  // state of the word held in the input register
  typedef struct packed {
    logic valid;
    logic last;
    logic loud;
  } blk_t;

endpackage

// ----- hw/rtl/asd_cfg.sv -----
// apb register file and silence target product
// depends on asd_pkg
module asd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asd_pkg::ADDR_W-1:0]  paddr,
  input  logic [asd_pkg::DATA_W-1:0]  pwdata,
  output logic [asd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output asd_pkg::cfg_t               cfg
);

  logic [asd_pkg::TMO_W-1:0] timeout;
  logic [asd_pkg::BPS_W-1:0] bps;
  logic [asd_pkg::THR_W-1:0] threshold;
  logic [asd_pkg::TGT_W-1:0] target;
  logic [asd_pkg::TGT_W-1:0] target_next;
  asd_pkg::reg_idx_t         idx;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = asd_pkg::reg_idx_t'(paddr[asd_pkg::ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= asd_pkg::TMO_RST;
      bps       <= asd_pkg::BPS_RST;
      threshold <= asd_pkg::THR_RST;
    end else if (wr) begin
      case (idx)
        asd_pkg::REG_TIMEOUT:   timeout   <= pwdata[asd_pkg::TMO_W-1:0];
        asd_pkg::REG_BPS:       bps       <= pwdata[asd_pkg::BPS_W-1:0];
        asd_pkg::REG_THRESHOLD: threshold <= pwdata[asd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // byte target = timeout * byte rate (zero for a negative timeout), registered after the multiplier
  assign target_next = timeout[asd_pkg::TMO_W-1] ? '0 :
      asd_pkg::TGT_W'(timeout[asd_pkg::TMO_W-2:0]) * asd_pkg::TGT_W'(bps);

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= asd_pkg::TGT_W'(asd_pkg::TMO_RST) * asd_pkg::TGT_W'(asd_pkg::BPS_RST);
    end else begin
      target <= target_next;
    end
  end

  // read back
  always_comb begin
    case (idx)
      asd_pkg::REG_TIMEOUT:   prdata = asd_pkg::DATA_W'(timeout);
      asd_pkg::REG_BPS:       prdata = asd_pkg::DATA_W'(bps);
      asd_pkg::REG_THRESHOLD: prdata = asd_pkg::DATA_W'(threshold);
      default:                prdata = '0;
    endcase
  end

  assign cfg.tmo_neg   = timeout[asd_pkg::TMO_W-1];
  assign cfg.threshold = threshold;
  assign cfg.target    = target;

endmodule

// ----- hw/rtl/asd_blk.sv -----
// input register and per-block sample and loud counters
// depends on asd_pkg and assert_macros.svh
`include "assert_macros.svh"

module asd_blk #(
  parameter  int MAX_BLOCK_SAMPLES = 8192,
  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  asd_pkg::sample_word_t       sample_item,
  input  logic [asd_pkg::THR_W-1:0]   threshold,
  input  logic                        adv,
  output asd_pkg::blk_t               blk,
  output logic [CNT_W-1:0]            n
);

  localparam int MW = CNT_W + 6;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_SAMPLES);

  logic                    s_valid;
  asd_pkg::sample_word_t   s_word;
  logic [CNT_W-1:0]        bs;
  logic [CNT_W-1:0]        lc;
  logic [CNT_W-1:0]        bs_next;
  logic [CNT_W-1:0]        lc_next;
  logic [asd_pkg::SMP_W:0] ext;
  logic [asd_pkg::SMP_W:0] mag;
  logic                    hot;
  logic                    loud;

  // input register; a new word enters when it is empty or as the held one moves on
  assign sample_stall = s_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s_word <= sample_item;
    end
  end

  // magnitude; the most negative sample maps to 32768
  assign ext = {s_word.sample[asd_pkg::SMP_W-1], s_word.sample};
  assign mag = s_word.sample[asd_pkg::SMP_W-1] ? (~ext + 1'b1) : ext;
  assign hot = mag >= {2'b00, threshold};

  // saturating counters including the held word
  assign bs_next = (bs < MAX_CNT) ? bs + CNT_W'(1) : bs;
  assign lc_next = (hot && lc < MAX_CNT) ? lc + CNT_W'(1) : lc;

  // loud >= floor(n/25) is the same as 25 * (loud + 1) > n
  assign loud = (lc_next != '0) &&
      ((MW'(lc_next) + MW'(1)) * MW'(asd_pkg::LOUD_DIV) > MW'(bs_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      bs <= '0;
      lc <= '0;
    end else if (adv) begin
      if (s_word.block_end) begin
        bs <= '0;
        lc <= '0;
      end else begin
        bs <= bs_next;
        lc <= lc_next;
      end
    end
  end

  assign blk.valid = s_valid;
  assign blk.last  = s_word.block_end;
  assign blk.loud  = loud;
  assign n         = bs_next;

  `ASD_ASSERT(a_lc_le_bs, lc <= bs, "loud count exceeds block sample count")
  `ASD_ASSERT_ALWAYS(a_rst_clears, rst |=> (bs == '0 && lc == '0 && !s_valid), "reset left state")

endmodule

// ----- hw/rtl/asd_sil.sv -----
// silence byte counter, timeout compare and result register
// depends on asd_pkg and assert_macros.svh
`include "assert_macros.svh"

module asd_sil #(
  parameter int CNT_W = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  asd_pkg::blk_t          blk,
  input  logic [CNT_W-1:0]       n,
  input  asd_pkg::cfg_t          cfg,
  output logic                   adv,
  output logic                   result_valid,
  input  logic                   result_stall,
  output asd_pkg::result_word_t  result_item
);

  logic [asd_pkg::SB_W-1:0] silent_bytes;
  logic [asd_pkg::SB_W:0]   sum;
  logic [asd_pkg::SB_W-1:0] sat;
  logic                     hit;
  logic                     fire;

  // the held word moves on unless it ends a block and the result slot is blocked
  assign adv  = blk.valid && (!blk.last || !result_valid || !result_stall);
  assign fire = adv && blk.last;

  // quiet block adds 2n bytes, saturating at all ones
  assign sum = {1'b0, silent_bytes} + (asd_pkg::SB_W + 1)'({n, 1'b0});
  assign sat = sum[asd_pkg::SB_W] ? '1 : sum[asd_pkg::SB_W-1:0];
  assign hit = {1'b0, sat} >= cfg.target;

  always_ff @(posedge clk) begin
    if (rst) begin
      silent_bytes <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      // counter is frozen while detection is disabled
      if (fire && !cfg.tmo_neg) begin
        if (blk.loud || hit) begin
          silent_bytes <= '0;
        end else begin
          silent_bytes <= sat;
        end
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (fire) begin
      result_item.silence_reached <= !cfg.tmo_neg && !blk.loud && hit;
      result_item.block_loud      <= !cfg.tmo_neg && blk.loud;
    end
  end

  `ASD_ASSERT(a_excl, result_valid |-> !(result_item.silence_reached && result_item.block_loud), "silence and loud reported together")
  `ASD_ASSERT(a_clear, (result_valid && result_item.silence_reached) |-> (silent_bytes == '0), "silence reported but counter not cleared")
  `ASD_ASSERT(a_fire, fire |=> result_valid, "block end produced no result word")

endmodule

// ----- hw/rtl/audio_silence_timeout_detector_top.sv -----
// the input register feeds the result register; a block-end word's result is held there
// throughput: one sample word per cycle unless a block-end word waits on result_stall
// a configuration write applies to the held word; the byte target passes its own register
// reset (rst, synchronous): registers return to 20 s, 176400 B/s, threshold 327;
// silence counter and block counters clear, no word is held
module audio_silence_timeout_detector_top #(
  parameter int MAX_BLOCK_SAMPLES = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asd_pkg::ADDR_W-1:0]  paddr,
  input  logic [asd_pkg::DATA_W-1:0]  pwdata,
  output logic [asd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  asd_pkg::sample_word_t       sample_item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output asd_pkg::result_word_t       result_item
);

  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);

  asd_pkg::cfg_t    cfg;
  asd_pkg::blk_t    blk;
  logic [CNT_W-1:0] n;
  logic             adv;

  // configuration registers
  asd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register and block counters
  asd_blk #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
  ) u_blk (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .threshold    (cfg.threshold),
    .adv          (adv),
    .blk          (blk),
    .n            (n)
  );

  // silence accounting and result register
  asd_sil #(
    .CNT_W (CNT_W)
  ) u_sil (
    .clk          (clk),
    .rst          (rst),
    .blk          (blk),
    .n            (n),
    .cfg          (cfg),
    .adv          (adv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
